>>> src/bmmc_pkg.sv
// ----------------------------------------------------------------------------
// bmmc_pkg
// Shared types, memory map constants and preset tables for the banked
// memory map controller.
// ----------------------------------------------------------------------------
package bmmc_pkg;

	localparam logic [15:0] BANK_BASE  = 16'hF000;
	localparam logic [15:0] PAGE_BASE  = 16'hFF00;
	localparam logic [15:0] ROM_BYTES  = 16'd3840;
	localparam logic [15:0] KEY_COUNT  = 16'd57;
	localparam logic [7:0]  PAGE_COUNT = 8'd6;

	localparam int RAM_DEPTH = 61440;
	localparam int RAM_AW    = 16;
	localparam int AUX_DEPTH = 2048;
	localparam int AUX_AW    = 11;
	localparam int ROM_AW    = 12;
	localparam logic [AUX_AW-1:0] KEY_BASE = 11'd1536;

	localparam logic [7:0] BANK_ROM   = 8'd0;
	localparam logic [7:0] BANK_KBD   = 8'd1;
	localparam logic [7:0] BANK_AUDIO = 8'd3;
	localparam logic [7:0] BANK_CLK   = 8'd4;
	localparam logic [2:0] CLK_PAGE   = 3'd3;

	typedef enum logic [3:0] {
		ACC_NONE,
		ACC_RAM,
		ACC_AUX,
		ACC_BANK,
		ACC_ROM,
		ACC_ZERO,
		ACC_KBD,
		ACC_CLK,
		ACC_AUDIO
	} acc_kind_t;

	typedef enum logic [1:0] {
		SRC_VAL,
		SRC_HOLD,
		SRC_RAM,
		SRC_AUX
	} bus_src_t;

	typedef struct packed {
		acc_kind_t         kind;
		logic [RAM_AW-1:0] ram_idx;
		logic [AUX_AW-1:0] aux_idx;
		logic [ROM_AW-1:0] rom_idx;
		logic [2:0]        audio_idx;
	} dec_t;

	function automatic logic [7:0] rom_byte(input logic [ROM_AW-1:0] idx);
		logic [7:0] b;
		case (idx)
			12'd0:   b = 8'heb;
			12'd1:   b = 8'h0e;
			12'd2:   b = 8'h04;
			12'd3:   b = 8'hdf;
			12'd4:   b = 8'hfe;
			12'd5:   b = 8'hf1;
			12'd6:   b = 8'hdb;
			12'd7:   b = 8'h02;
			12'd8:   b = 8'h00;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// clock handler page preset, everything else clears to zero
	function automatic logic [7:0] aux_init(input logic [AUX_AW-1:0] idx);
		logic [7:0] b;
		b = 8'h00;
		if (idx[10:8] == CLK_PAGE) begin
			case (idx[7:0])
				8'h00:   b = 8'hde;
				8'h01:   b = 8'hff;
				8'h02:   b = 8'hfe;
				8'h03:   b = 8'hdf;
				8'h04:   b = 8'hdf;
				8'hfe:   b = 8'hff;
				8'hff:   b = 8'h04;
				default: b = 8'h00;
			endcase
		end
		return b;
	endfunction

endpackage

>>> src/bmmc_decode.sv
// ----------------------------------------------------------------------------
// bmmc_decode
// Address decoder: maps a bus address and the current bank select value
// onto a target and its index in the RAM, handler/key store, boot ROM or registers.
// ----------------------------------------------------------------------------
module bmmc_decode (
	input  logic [15:0]        address,
	input  logic [7:0]         bank,
	output bmmc_pkg::dec_t     dec
);

	logic [15:0] offset;
	logic [15:0] page_off;
	logic [2:0]  page_sel;

	assign offset   = address - bmmc_pkg::BANK_BASE;
	assign page_off = address - bmmc_pkg::PAGE_BASE;
	assign page_sel = bank[2:0] - 3'd1;

	always_comb begin
		dec.kind      = bmmc_pkg::ACC_NONE;
		dec.ram_idx   = address;
		dec.aux_idx   = {page_sel, page_off[7:0]};
		dec.rom_idx   = offset[bmmc_pkg::ROM_AW-1:0];
		dec.audio_idx = offset[2:0] - 3'd1;
		if (address < bmmc_pkg::BANK_BASE - 16'd1) begin
			dec.kind = bmmc_pkg::ACC_RAM;
		end else if (address == bmmc_pkg::BANK_BASE - 16'd1) begin
			dec.kind = bmmc_pkg::ACC_BANK;
		end else if (address >= bmmc_pkg::PAGE_BASE) begin
			if (bank >= 8'd1 && bank <= bmmc_pkg::PAGE_COUNT) begin
				dec.kind = bmmc_pkg::ACC_AUX;
			end
		end else begin
			case (bank)
				bmmc_pkg::BANK_ROM: begin
					if (offset < bmmc_pkg::ROM_BYTES) dec.kind = bmmc_pkg::ACC_ROM;
					else dec.kind = bmmc_pkg::ACC_ZERO;
				end
				bmmc_pkg::BANK_KBD: begin
					if (offset == 16'd0) begin
						dec.kind = bmmc_pkg::ACC_KBD;
					end else if (offset <= bmmc_pkg::KEY_COUNT) begin
						dec.kind    = bmmc_pkg::ACC_AUX;
						dec.aux_idx = bmmc_pkg::KEY_BASE
							+ {3'd0, offset[7:0] - 8'd1};
					end
				end
				bmmc_pkg::BANK_AUDIO: begin
					if (offset >= 16'd1 && offset <= 16'd5) dec.kind = bmmc_pkg::ACC_AUDIO;
				end
				bmmc_pkg::BANK_CLK: begin
					if (offset == 16'd0) dec.kind = bmmc_pkg::ACC_CLK;
				end
				default: begin
					dec.kind = bmmc_pkg::ACC_NONE;
				end
			endcase
		end
	end

endmodule

>>> src/banked_memory_map_controller_top.sv
// ----------------------------------------------------------------------------
// banked_memory_map_controller_top
// Banked memory map controller: main RAM, bank select register, handler
// pages, boot ROM and the keyboard, audio and clock device windows.
// ----------------------------------------------------------------------------
// One transaction is taken per clock cycle while busy is low; its result is
// shown with done for the single cycle that follows the next clock edge and
// cannot be held off, so the receiver must take it two edges after acceptance.
// Writes land in the RAM and handler/key store at the acceptance edge and
// reads of those memories are registered at that edge. After reset busy
// stays high while all 2048 entries of the handler/key store are loaded with
// their preset values, one entry per cycle.
module banked_memory_map_controller_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] address,
	input  logic        action,
	input  logic [7:0]  write_data,
	output logic        done,
	output logic [7:0]  read_data,
	output logic        audio_reset_line,
	output logic [7:0]  audio_osc_select,
	output logic [7:0]  audio_reg_select,
	output logic [7:0]  audio_data_byte,
	output logic [7:0]  audio_direction
);

	logic [7:0] ram_mem [0:bmmc_pkg::RAM_DEPTH-1];
	logic [7:0] aux_mem [0:bmmc_pkg::AUX_DEPTH-1];

	bmmc_pkg::dec_t dec;
	logic           accept;
	logic           wr;

	logic                        clr_active_q;
	logic [bmmc_pkg::AUX_AW-1:0] clr_q;

	logic [7:0] bank_q;
	logic [7:0] kbd_q;
	logic [7:0] clkf_q;
	logic [7:0] audio_q [0:4];
	logic [7:0] bus_hold_q;

	logic [7:0] ram_rd_q;
	logic [7:0] aux_rd_q;

	logic               valid_s1;
	bmmc_pkg::bus_src_t src_s1;
	logic [7:0]         val_s1;
	logic [7:0]         bus;

	logic       done_q;
	logic [7:0] read_data_q;
	logic       aud_rst_q;
	logic [7:0] aud_osc_q;
	logic [7:0] aud_reg_q;
	logic [7:0] aud_dat_q;
	logic [7:0] aud_dir_q;

	bmmc_decode u_decode (
		.address (address),
		.bank    (bank_q),
		.dec     (dec)
	);

	assign busy   = clr_active_q;
	assign accept = start && !clr_active_q;
	assign wr     = accept && !action;

	// preset pass over the handler/key store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_q        <= '0;
		end else if (clr_active_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == {bmmc_pkg::AUX_AW{1'b1}}) clr_active_q <= 1'b0;
		end
	end

	// main ram
	always_ff @(posedge clk) begin
		if (wr && dec.kind == bmmc_pkg::ACC_RAM) ram_mem[dec.ram_idx] <= write_data;
		if (accept) ram_rd_q <= ram_mem[dec.ram_idx];
	end

	// handler pages and key table
	always_ff @(posedge clk) begin
		if (clr_active_q) begin
			aux_mem[clr_q] <= bmmc_pkg::aux_init(clr_q);
		end else if (wr && dec.kind == bmmc_pkg::ACC_AUX) begin
			aux_mem[dec.aux_idx] <= write_data;
		end
		if (accept) aux_rd_q <= aux_mem[dec.aux_idx];
	end

	// device registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= '0;
			kbd_q  <= '0;
			clkf_q <= '0;
			for (int i = 0; i < 5; i++) audio_q[i] <= '0;
		end else if (wr) begin
			case (dec.kind)
				bmmc_pkg::ACC_BANK: bank_q <= write_data;
				bmmc_pkg::ACC_KBD:  kbd_q  <= write_data;
				bmmc_pkg::ACC_CLK:  clkf_q <= write_data;
				bmmc_pkg::ACC_AUDIO: begin
					if (dec.audio_idx == 3'd0) audio_q[0] <= {7'd0, write_data[0]};
					else audio_q[dec.audio_idx] <= write_data;
				end
				default: ;
			endcase
		end
	end

	// access stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			src_s1   <= bmmc_pkg::SRC_HOLD;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (!action) begin
					src_s1 <= bmmc_pkg::SRC_VAL;
				end else begin
					case (dec.kind)
						bmmc_pkg::ACC_RAM:  src_s1 <= bmmc_pkg::SRC_RAM;
						bmmc_pkg::ACC_AUX:  src_s1 <= bmmc_pkg::SRC_AUX;
						bmmc_pkg::ACC_NONE: src_s1 <= bmmc_pkg::SRC_HOLD;
						default:            src_s1 <= bmmc_pkg::SRC_VAL;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			case (dec.kind)
				bmmc_pkg::ACC_ZERO:  val_s1 <= 8'd0;
				bmmc_pkg::ACC_BANK:  val_s1 <= action ? bank_q : write_data;
				bmmc_pkg::ACC_ROM:   val_s1 <= action ? bmmc_pkg::rom_byte(dec.rom_idx)
				                                      : write_data;
				bmmc_pkg::ACC_KBD:   val_s1 <= action ? kbd_q : write_data;
				bmmc_pkg::ACC_CLK:   val_s1 <= action ? clkf_q : write_data;
				bmmc_pkg::ACC_AUDIO: val_s1 <= action ? audio_q[dec.audio_idx] : write_data;
				default:             val_s1 <= write_data;
			endcase
		end
	end

	always_comb begin
		case (src_s1)
			bmmc_pkg::SRC_VAL:  bus = val_s1;
			bmmc_pkg::SRC_HOLD: bus = bus_hold_q;
			bmmc_pkg::SRC_RAM:  bus = ram_rd_q;
			bmmc_pkg::SRC_AUX:  bus = aux_rd_q;
			default:            bus = bus_hold_q;
		endcase
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q     <= 1'b0;
			bus_hold_q <= '0;
		end else begin
			done_q <= valid_s1;
			if (valid_s1) bus_hold_q <= bus;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			read_data_q <= bus;
			aud_rst_q   <= audio_q[0][0];
			aud_osc_q   <= audio_q[1];
			aud_reg_q   <= audio_q[2];
			aud_dat_q   <= audio_q[3];
			aud_dir_q   <= audio_q[4];
		end
	end

	assign done             = done_q;
	assign read_data        = read_data_q;
	assign audio_reset_line = aud_rst_q;
	assign audio_osc_select = aud_osc_q;
	assign audio_reg_select = aud_reg_q;
	assign audio_data_byte  = aud_dat_q;
	assign audio_direction  = aud_dir_q;

	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(valid_s1, 1) && $past(accept, 2))
		else $error("result without accepted transaction");

	a_hold_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !action |=> src_s1 != bmmc_pkg::SRC_HOLD)
		else $error("write left the bus value held");

	a_preset_complete: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_active_q) |-> $past(clr_q) == {bmmc_pkg::AUX_AW{1'b1}})
		else $error("preset pass ended early");

	a_audio_reset_bit: assert property (@(posedge clk) disable iff (!arst_n)
		audio_q[0][7:1] == 7'd0)
		else $error("audio reset register holds more than bit 0");

	a_no_write_in_preset: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !accept)
		else $error("transaction taken during preset pass");

endmodule
